// ===== sv/i2r_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and lookup functions for the integer to Roman
// numeral converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  localparam logic [SYMBOL_W-1:0] ASCII_I = 8'h49;
  localparam logic [SYMBOL_W-1:0] ASCII_V = 8'h56;
  localparam logic [SYMBOL_W-1:0] ASCII_X = 8'h58;
  localparam logic [SYMBOL_W-1:0] ASCII_L = 8'h4C;
  localparam logic [SYMBOL_W-1:0] ASCII_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] ASCII_D = 8'h44;
  localparam logic [SYMBOL_W-1:0] ASCII_M = 8'h4D;
  localparam logic [SYMBOL_W-1:0] ASCII_NUL = 8'h00;

  localparam logic [1:0] DEC_THOUSANDS = 2'd3;
  localparam logic [1:0] DEC_HUNDREDS  = 2'd2;
  localparam logic [1:0] DEC_TENS      = 2'd1;
  localparam logic [1:0] DEC_UNITS     = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_ONE,
    K_FIVE,
    K_TEN
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic       err;
    logic       last;
    logic [1:0] decade;
    kind_t      kind;
  } emit_t;

  // Place value of a decade.
  function automatic logic [VALUE_W-1:0] decade_weight(input logic [1:0] decade);
    logic [VALUE_W-1:0] w;
    case (decade)
      DEC_THOUSANDS: w = 12'd1000;
      DEC_HUNDREDS:  w = 12'd100;
      DEC_TENS:      w = 12'd10;
      DEC_UNITS:     w = 12'd1;
      default:       w = 12'd1;
    endcase
    return w;
  endfunction

  // Number of letters that one decimal digit writes.
  function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Which of the one, five and ten symbols stands at position k of a digit.
  function automatic kind_t digit_kind(input logic [DIGIT_W-1:0] d, input logic [1:0] k);
    kind_t r;
    if (d == 4'd9) begin
      r = (k == 2'd0) ? K_ONE : K_TEN;
    end else if (d == 4'd4) begin
      r = (k == 2'd0) ? K_ONE : K_FIVE;
    end else if (d >= 4'd5) begin
      r = (k == 2'd0) ? K_FIVE : K_ONE;
    end else begin
      r = K_ONE;
    end
    return r;
  endfunction

  // ASCII letter for a symbol kind within a decade.
  function automatic logic [SYMBOL_W-1:0] roman_letter(input logic [1:0] decade,
                                                       input kind_t kind);
    logic [SYMBOL_W-1:0] c;
    c = ASCII_NUL;
    case (decade)
      DEC_THOUSANDS: c = ASCII_M;
      DEC_HUNDREDS: begin
        case (kind)
          K_ONE:   c = ASCII_C;
          K_FIVE:  c = ASCII_D;
          K_TEN:   c = ASCII_M;
          default: c = ASCII_NUL;
        endcase
      end
      DEC_TENS: begin
        case (kind)
          K_ONE:   c = ASCII_X;
          K_FIVE:  c = ASCII_L;
          K_TEN:   c = ASCII_C;
          default: c = ASCII_NUL;
        endcase
      end
      DEC_UNITS: begin
        case (kind)
          K_ONE:   c = ASCII_I;
          K_FIVE:  c = ASCII_V;
          K_TEN:   c = ASCII_X;
          default: c = ASCII_NUL;
        endcase
      end
      default: c = ASCII_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/i2r_sub_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_sub_unit
// Shared compare and subtract unit used to peel decimal digits off the
// remaining value one place value at a time.
// ----------------------------------------------------------------------------
module i2r_sub_unit (
  input  logic [i2r_pkg::VALUE_W-1:0] a,
  input  logic [i2r_pkg::VALUE_W-1:0] b,
  output logic                        ge,
  output logic [i2r_pkg::VALUE_W-1:0] diff
);
  import i2r_pkg::*;

  logic [VALUE_W:0] wide_diff;

  // The borrow out of the subtraction doubles as the compare result.
  assign wide_diff = {1'b0, a} - {1'b0, b};
  assign ge        = ~wide_diff[VALUE_W];
  assign diff      = wide_diff[VALUE_W-1:0];

endmodule

// ===== sv/i2r_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_seq
// Sequencer: takes a value, extracts each decimal digit by repeated
// subtraction on the shared unit, and steps through the letters of each digit.
// ----------------------------------------------------------------------------
module i2r_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [i2r_pkg::VALUE_W-1:0] in_value,
  output logic                        busy,
  output i2r_pkg::emit_t              emit
);
  import i2r_pkg::*;

  state_t               state_r, state_nxt;
  logic [VALUE_W-1:0]   rem_r, rem_nxt;
  logic [DIGIT_W-1:0]   digit_r, digit_nxt;
  logic [1:0]           decade_r, decade_nxt;
  logic [1:0]           k_r, k_nxt;

  logic                 sub_ge;
  logic [VALUE_W-1:0]   sub_diff;
  logic [2:0]           len;
  logic                 final_letter;
  logic                 bad_value;

  i2r_sub_unit u_sub (
    .a    (rem_r),
    .b    (decade_weight(decade_r)),
    .ge   (sub_ge),
    .diff (sub_diff)
  );

  assign len          = digit_len(digit_r);
  assign final_letter = ({1'b0, k_r} == (len - 3'd1));
  assign bad_value    = (in_value == '0) || (in_value > MAX_VALUE);
  assign busy         = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    digit_r  <= digit_nxt;
    decade_r <= decade_nxt;
    k_r      <= k_nxt;
  end

  // Next state and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    digit_nxt  = digit_r;
    decade_nxt = decade_r;
    k_nxt      = k_r;
    case (state_r)
      ST_IDLE: begin
        if (start && !bad_value) begin
          state_nxt  = ST_DIGIT;
          rem_nxt    = in_value;
          digit_nxt  = '0;
          decade_nxt = DEC_THOUSANDS;
        end
      end
      ST_DIGIT: begin
        if (sub_ge) begin
          rem_nxt   = sub_diff;
          digit_nxt = digit_r + 4'd1;
        end else if (len == 3'd0) begin
          // A zero digit writes nothing; move on to the next place value, or finish after the units.
          if (decade_r == DEC_UNITS) begin
            state_nxt = ST_IDLE;
          end else begin
            decade_nxt = decade_r - 2'd1;
          end
        end else begin
          state_nxt = ST_EMIT;
          k_nxt     = '0;
        end
      end
      ST_EMIT: begin
        if (final_letter) begin
          // Nothing left below this digit ends the numeral early.
          if (rem_r == '0 || decade_r == DEC_UNITS) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt  = ST_DIGIT;
            decade_nxt = decade_r - 2'd1;
            digit_nxt  = '0;
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Letter request toward the output stage.
  always_comb begin
    emit.valid  = 1'b0;
    emit.err    = 1'b0;
    emit.last   = 1'b0;
    emit.decade = decade_r;
    emit.kind   = digit_kind(digit_r, k_r);
    case (state_r)
      ST_IDLE: begin
        if (start && bad_value) begin
          emit.valid = 1'b1;
          emit.err   = 1'b1;
          emit.last  = 1'b1;
        end
      end
      ST_EMIT: begin
        emit.valid = 1'b1;
        emit.last  = final_letter && (rem_r == '0);
      end
      default: begin
        emit.valid = 1'b0;
      end
    endcase
  end

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (digit_r <= 4'd9))
    else $error("digit counter ran past nine");

  a_rem_below_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !sub_ge)
    else $error("emitting a digit that was not fully extracted");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.last && !emit.err) |=> (state_r == ST_IDLE))
    else $error("sequencer still busy after the final letter");

  a_err_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.err) |-> (state_r == ST_IDLE && !busy))
    else $error("error result raised outside idle");

endmodule

// ===== sv/i2r_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2r_out_stage
// Output register: maps a letter request to its ASCII code and presents each
// result for one cycle with a strobe.
// ----------------------------------------------------------------------------
module i2r_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  i2r_pkg::emit_t               emit,
  output logic                         out_valid,
  output logic [i2r_pkg::SYMBOL_W-1:0] out_symbol,
  output logic                         out_last,
  output logic                         out_out_of_range
);
  import i2r_pkg::*;

  logic                valid_r;
  logic [SYMBOL_W-1:0] symbol_r, symbol_nxt;
  logic                last_r;
  logic                oor_r;

  assign symbol_nxt = emit.err ? ASCII_NUL : roman_letter(emit.decade, emit.kind);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    symbol_r <= symbol_nxt;
    last_r   <= emit.last;
    oor_r    <= emit.err;
  end

  assign out_valid        = valid_r;
  assign out_symbol       = symbol_r;
  assign out_last         = last_r;
  assign out_out_of_range = oor_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && oor_r) |-> (last_r && symbol_r == ASCII_NUL))
    else $error("error result must be a single last result");

  a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !oor_r) |-> (symbol_r != ASCII_NUL))
    else $error("numeral letter came out as zero");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |=> valid_r)
    else $error("letter request lost in the output register");

endmodule

// ===== sv/integer_to_roman_numeral_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_core
// Converts a 12-bit integer to its Roman numeral, one ASCII letter per result.
// ----------------------------------------------------------------------------
// A value is transferred when start is high and busy is low. Each result
// shows on the out_ ports for exactly one cycle while out_valid is high, in
// the cycle after it is produced, and the receiver has no way to stall it. For
// 1 to 3999 the letters come most significant digit first and out_last marks
// the final one. A value of 0 or above 3999 gives one result with symbol 0,
// out_last and out_out_of_range set, and busy never rises for it. A valid
// value keeps busy high while the shared compare and subtract unit extracts
// each decimal digit and while the letters of that digit are emitted;
// decades below the last nonzero digit are skipped.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [i2r_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  output logic [i2r_pkg::SYMBOL_W-1:0] out_symbol,
  output logic                         out_last,
  output logic                         out_out_of_range
);
  import i2r_pkg::*;

  emit_t emit;

  i2r_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_value (in_value),
    .busy     (busy),
    .emit     (emit)
  );

  i2r_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit             (emit),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule
